/* design/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg: shared widths and stage types
// Quaternion vector rotation pipeline definitions.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int DW  = 16;            // field width
    localparam int PW  = 2 * DW;        // 16x16 product
    localparam int SW  = PW + 2;        // sums of products
    localparam int MW  = SW + DW;       // sum times field
    localparam int NW  = MW + 2;        // numerator
    localparam int N2W = PW + 1;        // squared norm
    localparam int EW  = N2W + 1;       // divisor 2*|q|^2
    localparam int RW  = NW + 1;        // dividend 2*|num| + |q|^2
    localparam int QB  = DW + 1;        // quotient bits

    typedef logic signed [DW-1:0] fld_t;

    typedef struct packed {
        logic signed [PW-1:0] ww, xx, yy, zz;
        logic signed [PW-1:0] xv0, yv1, zv2;
        logic signed [PW-1:0] yv2, zv1, zv0, xv2, xv1, yv0;
        fld_t                 w, x, y, z;
        fld_t                 v0, v1, v2;
        logic                 zero;
    } st1_t;

    typedef struct packed {
        logic [N2W-1:0]       n2;
        logic signed [SW-1:0] s, ud, cx, cy, cz;
        fld_t                 w, x, y, z;
        fld_t                 v0, v1, v2;
        logic                 zero;
    } st2_t;

    typedef struct packed {
        logic signed [MW-1:0] ps0, ps1, ps2;
        logic signed [MW-1:0] pu0, pu1, pu2;
        logic signed [MW-1:0] pc0, pc1, pc2;
        logic [N2W-1:0]       n2;
        fld_t                 v0, v1, v2;
        logic                 zero;
    } st3_t;

    typedef struct packed {
        logic signed [NW-1:0] n0, n1, n2v;
        logic [N2W-1:0]       n2;
        fld_t                 v0, v1, v2;
        logic                 zero;
    } st4_t;

    typedef struct packed {
        logic [2:0][RW-1:0]   rem;
        logic [2:0][QB-1:0]   quo;
        logic [2:0]           neg;
        logic [EW-1:0]        e;
        fld_t                 v0, v1, v2;
        logic                 zero;
    } dv_t;

endpackage

/* design/quaternion_vector_rotation.sv */
// Each beat passes stages 1 to 4, the divider stages and the output register.
// Throughput: one beat per cycle while out_stall is low; the divider is one quotient bit per stage.
// Stages hold only while the stage ahead is full and stalled, so bubbles fill.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a vector by a quaternion, divides by its squared norm, rounds and saturates.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qvr_pkg::fld_t       quat_w,
    input  qvr_pkg::fld_t       quat_x,
    input  qvr_pkg::fld_t       quat_y,
    input  qvr_pkg::fld_t       quat_z,
    input  qvr_pkg::fld_t       vec_x,
    input  qvr_pkg::fld_t       vec_y,
    input  qvr_pkg::fld_t       vec_z,
    output logic                out_valid,
    input  logic                out_stall,
    output qvr_pkg::fld_t       rot_x,
    output qvr_pkg::fld_t       rot_y,
    output qvr_pkg::fld_t       rot_z,
    output logic                zero_quat,
    output logic                saturated
);
    import qvr_pkg::*;

    localparam int NS = QB + 6;     // stage count, output register last
    localparam int DV = 4;          // first divider stage

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    dv_t  dv_reg [QB+1];
    dv_t  dv_next [QB+1];

    fld_t rx_reg, ry_reg, rz_reg, rx_next, ry_next, rz_next;
    logic zq_reg, sat_reg, zq_next, sat_next;

    // stage k may load when empty or when stage k+1 loads
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 1: all 16x16 products
    always_comb
    begin
        s1_next.ww  = quat_w * quat_w;
        s1_next.xx  = quat_x * quat_x;
        s1_next.yy  = quat_y * quat_y;
        s1_next.zz  = quat_z * quat_z;
        s1_next.xv0 = quat_x * vec_x;
        s1_next.yv1 = quat_y * vec_y;
        s1_next.zv2 = quat_z * vec_z;
        s1_next.yv2 = quat_y * vec_z;
        s1_next.zv1 = quat_z * vec_y;
        s1_next.zv0 = quat_z * vec_x;
        s1_next.xv2 = quat_x * vec_z;
        s1_next.xv1 = quat_x * vec_y;
        s1_next.yv0 = quat_y * vec_x;
        s1_next.w = quat_w;
        s1_next.x = quat_x;
        s1_next.y = quat_y;
        s1_next.z = quat_z;
        s1_next.v0 = vec_x;
        s1_next.v1 = vec_y;
        s1_next.v2 = vec_z;
        s1_next.zero = (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
    end

    // stage 2: norm, scalar term, dot and cross products
    always_comb
    begin
        logic signed [SW-1:0] uu;
        logic signed [SW-1:0] ww;
        ww = SW'(s1_reg.ww);
        uu = SW'(s1_reg.xx) + SW'(s1_reg.yy) + SW'(s1_reg.zz);
        s2_next.n2 = N2W'(ww + uu);
        s2_next.s  = ww - uu;
        s2_next.ud = SW'(s1_reg.xv0) + SW'(s1_reg.yv1) + SW'(s1_reg.zv2);
        s2_next.cx = SW'(s1_reg.yv2) - SW'(s1_reg.zv1);
        s2_next.cy = SW'(s1_reg.zv0) - SW'(s1_reg.xv2);
        s2_next.cz = SW'(s1_reg.xv1) - SW'(s1_reg.yv0);
        s2_next.w = s1_reg.w;
        s2_next.x = s1_reg.x;
        s2_next.y = s1_reg.y;
        s2_next.z = s1_reg.z;
        s2_next.v0 = s1_reg.v0;
        s2_next.v1 = s1_reg.v1;
        s2_next.v2 = s1_reg.v2;
        s2_next.zero = s1_reg.zero;
    end

    // stage 3: wide products
    always_comb
    begin
        s3_next.ps0 = s2_reg.s * s2_reg.v0;
        s3_next.ps1 = s2_reg.s * s2_reg.v1;
        s3_next.ps2 = s2_reg.s * s2_reg.v2;
        s3_next.pu0 = s2_reg.ud * s2_reg.x;
        s3_next.pu1 = s2_reg.ud * s2_reg.y;
        s3_next.pu2 = s2_reg.ud * s2_reg.z;
        s3_next.pc0 = s2_reg.cx * s2_reg.w;
        s3_next.pc1 = s2_reg.cy * s2_reg.w;
        s3_next.pc2 = s2_reg.cz * s2_reg.w;
        s3_next.n2 = s2_reg.n2;
        s3_next.v0 = s2_reg.v0;
        s3_next.v1 = s2_reg.v1;
        s3_next.v2 = s2_reg.v2;
        s3_next.zero = s2_reg.zero;
    end

    // stage 4: numerators
    always_comb
    begin
        s4_next.n0  = NW'(s3_reg.ps0) + (NW'(s3_reg.pu0) <<< 1) + (NW'(s3_reg.pc0) <<< 1);
        s4_next.n1  = NW'(s3_reg.ps1) + (NW'(s3_reg.pu1) <<< 1) + (NW'(s3_reg.pc1) <<< 1);
        s4_next.n2v = NW'(s3_reg.ps2) + (NW'(s3_reg.pu2) <<< 1) + (NW'(s3_reg.pc2) <<< 1);
        s4_next.n2 = s3_reg.n2;
        s4_next.v0 = s3_reg.v0;
        s4_next.v1 = s3_reg.v1;
        s4_next.v2 = s3_reg.v2;
        s4_next.zero = s3_reg.zero;
    end

    // divider setup and one quotient bit per stage, round half away from zero
    always_comb
    begin
        logic signed [NW-1:0] nm [3];
        logic [RW-1:0]        trial;
        nm[0] = s4_reg.n0;
        nm[1] = s4_reg.n1;
        nm[2] = s4_reg.n2v;
        dv_next[0].e = {s4_reg.n2, 1'b0};
        for (int l = 0; l < 3; l++)
        begin
            dv_next[0].neg[l] = nm[l][NW-1];
            dv_next[0].rem[l] = ({1'b0, (nm[l][NW-1] ? -nm[l] : nm[l])} << 1)
                                + RW'(s4_reg.n2);
            dv_next[0].quo[l] = '0;
        end
        dv_next[0].v0 = s4_reg.v0;
        dv_next[0].v1 = s4_reg.v1;
        dv_next[0].v2 = s4_reg.v2;
        dv_next[0].zero = s4_reg.zero;
        for (int j = 1; j <= QB; j++)
        begin
            dv_next[j] = dv_reg[j-1];
            for (int l = 0; l < 3; l++)
            begin
                trial = RW'(dv_reg[j-1].e) << (QB - j);
                if (dv_reg[j-1].rem[l] >= trial)
                begin
                    dv_next[j].rem[l] = dv_reg[j-1].rem[l] - trial;
                    dv_next[j].quo[l][QB-j] = 1'b1;
                end
            end
        end
    end

    // output: sign, clip, zero-quaternion bypass
    always_comb
    begin
        logic signed [QB:0] sv [3];
        fld_t               cl [3];
        logic               sat;
        sat = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            sv[l] = dv_reg[QB].neg[l] ? -$signed({1'b0, dv_reg[QB].quo[l]})
                                      : $signed({1'b0, dv_reg[QB].quo[l]});
            if (sv[l] > (QB+1)'(32767))
            begin
                cl[l] = 16'sh7FFF;
                sat = 1'b1;
            end
            else if (sv[l] < -(QB+1)'(32768))
            begin
                cl[l] = 16'sh8000;
                sat = 1'b1;
            end
            else
                cl[l] = DW'(sv[l]);
        end
        zq_next = dv_reg[QB].zero;
        if (dv_reg[QB].zero)
        begin
            rx_next = dv_reg[QB].v0;
            ry_next = dv_reg[QB].v1;
            rz_next = dv_reg[QB].v2;
            sat_next = 1'b0;
        end
        else
        begin
            rx_next = cl[0];
            ry_next = cl[1];
            rz_next = cl[2];
            sat_next = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s1_reg <= s1_next;
        if (en[1])
            s2_reg <= s2_next;
        if (en[2])
            s3_reg <= s3_next;
        if (en[3])
            s4_reg <= s4_next;
        for (int j = 0; j <= QB; j++)
            if (en[DV+j])
                dv_reg[j] <= dv_next[j];
        if (en[NS-1])
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            zq_reg <= zq_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign rot_x = rx_reg;
    assign rot_y = ry_reg;
    assign rot_z = rz_reg;
    assign zero_quat = zq_reg;
    assign saturated = sat_reg;

endmodule

/* design/qvr_checker.sv */
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the rotation pipeline.
// ----------------------------------------------------------------------------
module qvr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_stall,
    input qvr_pkg::fld_t rot_x,
    input qvr_pkg::fld_t rot_y,
    input qvr_pkg::fld_t rot_z,
    input logic          zero_quat,
    input logic          saturated
);
    // identity bypass never clips
    a_zero_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_quat |-> !saturated)
        else $error("saturated set on identity beat");

    // a clipped beat shows a rail value somewhere
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (rot_x == 16'sh7FFF) || (rot_x == 16'sh8000) ||
            (rot_y == 16'sh7FFF) || (rot_y == 16'sh8000) ||
            (rot_z == 16'sh7FFF) || (rot_z == 16'sh8000))
        else $error("saturated without rail value");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
            && $stable(saturated) && $stable(zero_quat))
        else $error("output beat changed under stall");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .zero_quat (zero_quat),
    .saturated (saturated)
);
